### sv/srq_pkg.sv
package srq_pkg;

    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_ROTATE = 2'd2,
        OP_SORT   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What one cell does with its entry in the coming cycle.
    typedef enum logic [2:0] {
        CELL_HOLD    = 3'd0,
        CELL_LOAD    = 3'd1,
        CELL_SHIFT   = 3'd2,
        CELL_WRAP    = 3'd3,
        CELL_SORT_LO = 3'd4,
        CELL_SORT_HI = 3'd5
    } cell_cmd_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] front_value;
        logic                     front_valid;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
    } rsp_t;

endpackage

### sv/srq_cell.sv
module srq_cell (
    input  logic                              clk,
    input  srq_pkg::cell_cmd_t                cmd,
    input  logic signed [srq_pkg::DATA_W-1:0] push_value,
    input  logic signed [srq_pkg::DATA_W-1:0] front_data,
    input  logic signed [srq_pkg::DATA_W-1:0] left_data,
    input  logic signed [srq_pkg::DATA_W-1:0] right_data,
    output logic signed [srq_pkg::DATA_W-1:0] data
);

    logic signed [srq_pkg::DATA_W-1:0] data_reg;
    logic signed [srq_pkg::DATA_W-1:0] data_next;

    // Swaps happen only on a strict inversion, so equal entries keep their order.
    always_comb
    begin
        unique case (cmd)
            srq_pkg::CELL_HOLD:    data_next = data_reg;
            srq_pkg::CELL_LOAD:    data_next = push_value;
            srq_pkg::CELL_SHIFT:   data_next = right_data;
            srq_pkg::CELL_WRAP:    data_next = front_data;
            srq_pkg::CELL_SORT_LO: data_next = (right_data < data_reg) ? right_data : data_reg;
            srq_pkg::CELL_SORT_HI: data_next = (data_reg < left_data) ? left_data : data_reg;
            default:               data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### sv/sortable_rotating_queue_unit.sv
// Sortable rotating queue: a bounded FIFO of DEPTH signed 32-bit entries.
// A request beat (req.op, req.value) is taken on a rising edge with start
// high and busy low. Each request gives exactly one response beat on rsp,
// marked by done for a single cycle; the receiver cannot hold it off.
// For push, pop and rotate, done is high in the cycle after the
// request, and busy stays low, so a new request may be issued every cycle.
// Sort holds busy high while it runs DEPTH odd-even transposition passes,
// one pass per cycle across the row of cells, and done follows in the cycle
// after the last pass, when busy falls again.
// The entries sit in a row of cells with the front in cell zero; pop and
// rotate shift the row by one place towards the front.
// The response reports the front entry, its valid flag, the count and the
// status after the operation. A push on a full queue is dropped with status
// full; a pop on an empty queue is ignored with status empty.
// Reset empties the queue and clears busy and done; the entry cells are not
// reset, as only occupied cells are ever read.
module sortable_rotating_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  srq_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output srq_pkg::rsp_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);
    localparam int RW = srq_pkg::COUNT_W;

    logic                                busy_reg;
    logic                                done_reg;
    logic [CW-1:0]                       count_reg;
    logic [SW-1:0]                       pass_reg;
    srq_pkg::status_t                    status_reg;

    logic                                accept;
    logic                                full;
    logic                                empty;
    logic signed [srq_pkg::DATA_W-1:0]   cell_data [DEPTH];

    assign accept = start && !busy_reg;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [srq_pkg::DATA_W-1:0] left_in;
            logic signed [srq_pkg::DATA_W-1:0] right_in;
            srq_pkg::cell_cmd_t                cell_cmd;

            if (i == 0)
            begin : g_first
                assign left_in = cell_data[0];
            end
            else
            begin : g_inner_l
                assign left_in = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_in = cell_data[i];
            end
            else
            begin : g_inner_r
                assign right_in = cell_data[i+1];
            end

            always_comb
            begin
                cell_cmd = srq_pkg::CELL_HOLD;
                if (busy_reg)
                begin
                    // Pair (i, i+1) is compared when i has the parity of the pass.
                    if ((1'(i % 2) == pass_reg[0]) && (CW'(i + 1) < count_reg))
                        cell_cmd = srq_pkg::CELL_SORT_LO;
                    else if ((i >= 1) && (1'((i + 1) % 2) == pass_reg[0])
                             && (CW'(i) < count_reg))
                        cell_cmd = srq_pkg::CELL_SORT_HI;
                end
                else if (accept)
                begin
                    unique case (req.op)
                        srq_pkg::OP_PUSH:
                            if (!full && (count_reg == CW'(i)))
                                cell_cmd = srq_pkg::CELL_LOAD;
                        srq_pkg::OP_POP:
                            if (!empty)
                                cell_cmd = srq_pkg::CELL_SHIFT;
                        srq_pkg::OP_ROTATE:
                            if (count_reg >= CW'(2))
                            begin
                                if (CW'(i + 1) == count_reg)
                                    cell_cmd = srq_pkg::CELL_WRAP;
                                else if (CW'(i + 1) < count_reg)
                                    cell_cmd = srq_pkg::CELL_SHIFT;
                            end
                        srq_pkg::OP_SORT:
                            cell_cmd = srq_pkg::CELL_HOLD;
                        default:
                            cell_cmd = srq_pkg::CELL_HOLD;
                    endcase
                end
            end

            srq_cell u_cell (
                .clk        (clk),
                .cmd        (cell_cmd),
                .push_value (req.value),
                .front_data (cell_data[0]),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            pass_reg   <= '0;
            status_reg <= srq_pkg::ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                if (pass_reg == SW'(DEPTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    pass_reg <= '0;
                end
                else
                begin
                    pass_reg <= pass_reg + 1'b1;
                end
            end
            else if (accept)
            begin
                status_reg <= srq_pkg::ST_OK;
                unique case (req.op)
                    srq_pkg::OP_PUSH:
                    begin
                        done_reg <= 1'b1;
                        if (full)
                            status_reg <= srq_pkg::ST_FULL;
                        else
                            count_reg <= count_reg + 1'b1;
                    end
                    srq_pkg::OP_POP:
                    begin
                        done_reg <= 1'b1;
                        if (empty)
                            status_reg <= srq_pkg::ST_EMPTY;
                        else
                            count_reg <= count_reg - 1'b1;
                    end
                    srq_pkg::OP_ROTATE:
                        done_reg <= 1'b1;
                    srq_pkg::OP_SORT:
                    begin
                        busy_reg <= 1'b1;
                        pass_reg <= '0;
                    end
                    default:
                        done_reg <= 1'b1;
                endcase
            end
        end
    end

    assign busy            = busy_reg;
    assign done            = done_reg;
    assign rsp.front_value = empty ? '0 : cell_data[0];
    assign rsp.front_valid = !empty;
    assign rsp.count       = RW'(count_reg);
    assign rsp.status      = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && busy_reg))
        else $error("response beat while a sort is running");

    a_quick_op_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.op != srq_pkg::OP_SORT)) |=> done_reg)
        else $error("single-cycle operation gave no response beat");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == srq_pkg::ST_FULL)) |-> full)
        else $error("full status with room in the queue");

endmodule
